FILE: rtl/core/isort_pkg.sv
package isort_pkg;

  // Default configuration of the sorter.
  localparam int SortDepthDefault = 32;
  localparam int KeyBitsDefault   = 16;

  // Field widths fixed by the interface.
  localparam int FieldBits = 16;

  // One input beat.
  typedef struct packed {
    logic [FieldBits-1:0] sort_key;
    logic [FieldBits-1:0] tag;
    logic                 final_item;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [FieldBits-1:0] out_key;
    logic [FieldBits-1:0] out_tag;
    logic                 end_of_run;
    logic                 overflow;
  } result_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the new entry, moving larger entries up by one
    logic drain;   // move every entry down by one toward the head
  } cell_ctl_t;

endpackage

FILE: rtl/core/isort_cell.sv
module isort_cell #(
  parameter int KEY_W = isort_pkg::KeyBitsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  isort_pkg::cell_ctl_t             ctl,
  input  logic [KEY_W-1:0]                 new_key,
  input  logic [isort_pkg::FieldBits-1:0]  new_tag,
  input  logic                             prev_shift,
  input  logic                             prev_valid,
  input  logic [KEY_W-1:0]                 prev_key,
  input  logic [isort_pkg::FieldBits-1:0]  prev_tag,
  input  logic                             next_valid,
  input  logic [KEY_W-1:0]                 next_key,
  input  logic [isort_pkg::FieldBits-1:0]  next_tag,
  output logic                             valid,
  output logic [KEY_W-1:0]                 key,
  output logic [isort_pkg::FieldBits-1:0]  tag,
  output logic                             shift
);

  // This cell is at or past the insertion point: it is empty or holds a
  // strictly larger key, so equal keys stay ahead of the new one.
  assign shift = !valid || (key > new_key);

  // Valid bit of the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      valid <= next_valid;
    end else if (ctl.insert && shift) begin
      valid <= prev_shift ? prev_valid : 1'b1;
    end
  end

  // Entry contents: take the lower neighbor's entry when the insertion point
  // lies below, the new entry when this cell is the insertion point.
  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      key <= next_key;
      tag <= next_tag;
    end else if (ctl.insert && shift) begin
      if (prev_shift) begin
        key <= prev_key;
        tag <= prev_tag;
      end else begin
        key <= new_key;
        tag <= new_tag;
      end
    end
  end

endmodule

FILE: rtl/core/insertion_sorter.sv
// Channel | Direction | Handshake                  | Beat
// item    | in        | item_valid / item_stall    | isort_pkg::item_t
// result  | out       | result_valid / result_stall| isort_pkg::result_t
//
// An item that is not final is inserted in the single cycle it is accepted.
// A final item is inserted, then the run drains one result per cycle from the
// head of the cell chain while the result side does not stall; item_stall is
// high while the run drains.
// Items arriving while all SORT_DEPTH cells are full are dropped.
// Reset empties every cell and clears the overflow mark; result_stall holds
// the result register and pauses the drain.
module insertion_sorter #(
  parameter int SORT_DEPTH = isort_pkg::SortDepthDefault,
  parameter int KEY_BITS   = isort_pkg::KeyBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  isort_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output isort_pkg::result_t result
);

  localparam int FW    = isort_pkg::FieldBits;
  localparam int KEY_W = (KEY_BITS < FW) ? KEY_BITS : FW;

  logic             cell_valid [SORT_DEPTH];
  logic [KEY_W-1:0] cell_key   [SORT_DEPTH];
  logic [FW-1:0]    cell_tag   [SORT_DEPTH];
  logic             cell_shift [SORT_DEPTH];

  logic                 draining;
  logic                 dropped;
  logic                 accept;
  logic                 full;
  logic                 out_free;
  logic                 drain_step;
  logic                 run_end;
  isort_pkg::cell_ctl_t ctl;

  // Input handshake and chain control.
  assign item_stall = draining;
  assign accept     = item_valid && !draining;
  assign full       = cell_valid[SORT_DEPTH-1];
  assign out_free   = !result_valid || !result_stall;
  assign drain_step = draining && out_free;
  assign run_end    = !cell_valid[1];
  assign ctl.insert = accept && !full;
  assign ctl.drain  = drain_step;

  // The chain of compare-and-shift cells.
  for (genvar i = 0; i < SORT_DEPTH; i++) begin : g_cell
    logic             p_shift;
    logic             p_valid;
    logic [KEY_W-1:0] p_key;
    logic [FW-1:0]    p_tag;
    logic             n_valid;
    logic [KEY_W-1:0] n_key;
    logic [FW-1:0]    n_tag;

    if (i == 0) begin : g_head
      assign p_shift = 1'b0;
      assign p_valid = 1'b0;
      assign p_key   = '0;
      assign p_tag   = '0;
    end else begin : g_mid
      assign p_shift = cell_shift[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_key   = cell_key[i-1];
      assign p_tag   = cell_tag[i-1];
    end

    if (i == SORT_DEPTH - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_key   = '0;
      assign n_tag   = '0;
    end else begin : g_body
      assign n_valid = cell_valid[i+1];
      assign n_key   = cell_key[i+1];
      assign n_tag   = cell_tag[i+1];
    end

    isort_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_key    (item.sort_key[KEY_W-1:0]),
      .new_tag    (item.tag),
      .prev_shift (p_shift),
      .prev_valid (p_valid),
      .prev_key   (p_key),
      .prev_tag   (p_tag),
      .next_valid (n_valid),
      .next_key   (n_key),
      .next_tag   (n_tag),
      .valid      (cell_valid[i]),
      .key        (cell_key[i]),
      .tag        (cell_tag[i]),
      .shift      (cell_shift[i])
    );
  end

  // Run control: drain after a final beat, note dropped items.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else if (drain_step && run_end) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else if (accept) begin
      if (full) begin
        dropped <= 1'b1;
      end
      if (item.final_item) begin
        draining <= 1'b1;
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (drain_step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload, taken from the head cell.
  always_ff @(posedge clk) begin
    if (drain_step) begin
      result.out_key    <= FW'(cell_key[0]);
      result.out_tag    <= cell_tag[0];
      result.end_of_run <= run_end;
      result.overflow   <= dropped;
    end
  end

endmodule

FILE: verif/testbench.sv
// Scoreboard: keeps its own copy of the sorted store and queues the beats
// that each final item is expected to release.
class sort_scoreboard;
  int depth;
  logic [15:0] key_mask;
  logic [15:0] held_keys[$];
  logic [15:0] held_tags[$];
  bit dropped;
  isort_pkg::result_t sorted_beats[$];
  int mismatches;

  function new(int store_depth, int key_bits);
    depth = store_depth;
    key_mask = (key_bits >= 16) ? 16'hFFFF : 16'((32'h1 << key_bits) - 1);
    dropped = 1'b0;
    mismatches = 0;
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function int pending();
    return sorted_beats.size();
  endfunction

  // Insert an accepted item after any equal keys; on a final item, queue the
  // whole list in order and empty the store.
  task note_item(isort_pkg::item_t it);
    logic [15:0] k;
    int pos;
    int n;
    isort_pkg::result_t r;
    k = it.sort_key & key_mask;
    if (held_keys.size() >= depth) begin
      dropped = 1'b1;
    end else begin
      pos = held_keys.size();
      while (pos > 0 && held_keys[pos-1] > k) pos--;
      held_keys.insert(pos, k);
      held_tags.insert(pos, it.tag);
    end
    if (it.final_item) begin
      n = held_keys.size();
      for (int i = 0; i < n; i++) begin
        r.out_key    = held_keys[i];
        r.out_tag    = held_tags[i];
        r.end_of_run = (i == n - 1);
        r.overflow   = dropped;
        sorted_beats.push_back(r);
      end
      held_keys.delete();
      held_tags.delete();
      dropped = 1'b0;
    end
  endtask

  // Compare one accepted result beat with the oldest expected beat.
  task check_result(isort_pkg::result_t got);
    isort_pkg::result_t want;
    if (sorted_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat key=%h tag=%h",
                                got.out_key, got.out_tag));
      return;
    end
    want = sorted_beats.pop_front();
    if (got.out_key !== want.out_key)
      report_mismatch($sformatf("out_key %h, expected %h", got.out_key, want.out_key));
    if (got.out_tag !== want.out_tag)
      report_mismatch($sformatf("out_tag %h, expected %h", got.out_tag, want.out_tag));
    if (got.end_of_run !== want.end_of_run)
      report_mismatch($sformatf("end_of_run %b, expected %b (key %h)",
                                got.end_of_run, want.end_of_run, want.out_key));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, expected %b (key %h)",
                                got.overflow, want.overflow, want.out_key));
  endtask
endclass

module testbench;
  localparam int SortDepth   = isort_pkg::SortDepthDefault;
  localparam int KeyBits     = isort_pkg::KeyBitsDefault;
  localparam int HoldCycles  = 400;
  localparam int TailCycles  = 2 * SortDepth + 20;
  localparam int CycleLimit  = 200000;
  localparam int ItemTarget  = 180;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  isort_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  isort_pkg::result_t result;

  sort_scoreboard sb;
  int cycle_count = 0;
  int items_sent = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  bit hold_request = 1'b0;

  insertion_sorter #(
    .SORT_DEPTH(SortDepth),
    .KEY_BITS  (KeyBits)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // Clock generation.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Monitors: an item beat feeds the scoreboard, a result beat is checked.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) sb.note_item(item);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Keys: full range, a narrow range that forces ties, or an extreme.
  function automatic logic [15:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom);
    if (r < 8) return 16'($urandom_range(0, 7));
    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic isort_pkg::item_t make_item(logic [15:0] k, logic [15:0] t, logic f);
    isort_pkg::item_t it;
    it.sort_key   = k;
    it.tag        = t;
    it.final_item = f;
    return it;
  endfunction

  // Present one beat, hold it until accepted, then possibly idle for a while.
  task send_item(isort_pkg::item_t it);
    int n;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
    n = pick_gap(sender_calm);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // A run of random items, the last one final.
  task send_run(int len);
    sender_calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++)
      send_item(make_item(pick_key(), 16'($urandom), i == len - 1));
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else if (receiver_calm) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else begin
        n = pick_gap(1'b0);
        if (n > 0) begin
          result_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      receiver_calm = ($urandom_range(0, 9) == 0);
    end
  end

  // Stimulus and end of run.
  initial begin
    sb = new(SortDepth, KeyBits);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single item that is final at once.
    send_item(make_item(16'h0000, 16'hFFFF, 1'b1));
    // Extremes with duplicated keys, checking that ties keep arrival order.
    send_item(make_item(16'hFFFF, 16'h0001, 1'b0));
    send_item(make_item(16'h0000, 16'h0002, 1'b0));
    send_item(make_item(16'h8000, 16'h0003, 1'b0));
    send_item(make_item(16'hFFFF, 16'h0004, 1'b0));
    send_item(make_item(16'h0000, 16'h0005, 1'b1));
    // All keys equal.
    for (int i = 0; i < 5; i++)
      send_item(make_item(16'h1234, 16'(16'h0100 + i), i == 4));
    // Strictly descending keys, so every insertion shifts the whole list.
    for (int i = 0; i < 6; i++)
      send_item(make_item(16'(16'h0050 - 16'h0010 * i), 16'(16'hAAAA ^ i), i == 5));
    // Alternating bit patterns, already in order.
    send_item(make_item(16'h5555, 16'hAAAA, 1'b0));
    send_item(make_item(16'hAAAA, 16'h5555, 1'b1));

    // Overflow run while the result side holds off, so the drain backs up
    // into the item channel.
    hold_request = 1'b1;
    send_run(SortDepth + 4);
    // Exactly full, then one past full with the final item dropped.
    send_run(SortDepth);
    send_run(SortDepth + 1);

    // Random runs, mostly short.
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 19) < 2) send_run($urandom_range(SortDepth - 2, SortDepth + 8));
      else send_run($urandom_range(1, 8));
    end
    item_valid <= 1'b0;

    // Step past the last accepting edge so its beat has reached the scoreboard.
    do @(posedge clk); while (sb.pending() != 0);
    repeat (TailCycles) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
